FILE: rtl/lpmf_pkg.sv
// Shared constants, codes and interface structs of the length-prefixed message FIFO.
package lpmf_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int MAX_READ    = 64;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int RL_W   = $clog2(MAX_READ + 1);
  localparam int LIM_W  = 7;
  localparam int SUM_W  = ((CNT_W > 9) ? CNT_W : 9) + 1;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_NOSPACE = 3'd1,
    STAT_EMPTY   = 3'd2,
    STAT_ZEROLIM = 3'd3,
    STAT_SEQ     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD_CAP,
    S_STREAM,
    S_ZERO_BEAT,
    S_PATCH
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic             load;
    status_t          status;
    logic [7:0]       data;
    logic             byte_valid;
    logic             last;
    logic [CNT_W-1:0] used;
    logic [7:0]       head;
  } beat_t;

endpackage

FILE: rtl/lpmf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lpmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/lpmf_out.sv
// Output register stage of the result channel.
module lpmf_out (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lpmf_pkg::beat_t            beat,
  output logic                       free,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_status,
  output logic [7:0]                 out_out_byte,
  output logic                       out_byte_valid,
  output logic                       out_last,
  output logic [lpmf_pkg::CNT_W-1:0] out_used_bytes,
  output logic [7:0]                 out_head_length
);

  logic            valid_r;
  logic            valid_nxt;
  lpmf_pkg::beat_t beat_r;

  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (beat.load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat.load) begin
      beat_r <= beat;
    end
  end

  assign out_valid       = valid_r;
  assign out_status      = beat_r.status;
  assign out_out_byte    = beat_r.data;
  assign out_byte_valid  = beat_r.byte_valid;
  assign out_last        = beat_r.last;
  assign out_used_bytes  = beat_r.used;
  assign out_head_length = beat_r.head;

endmodule

FILE: rtl/lpmf_ctrl.sv
// Command sequencer: ring pointers, occupancy, head length and the read stream.
module lpmf_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_operation,
  input  logic [7:0]                  in_msg_length,
  input  logic [7:0]                  in_payload,
  input  logic [lpmf_pkg::LIM_W-1:0]  in_read_limit,
  input  logic                        out_free,
  output lpmf_pkg::ram_req_t          ram_req,
  input  logic [7:0]                  ram_rdata,
  output lpmf_pkg::beat_t             beat
);

  localparam int AW = lpmf_pkg::ADDR_W;
  localparam int CW = lpmf_pkg::CNT_W;
  localparam int RW = lpmf_pkg::RL_W;
  localparam int SW = lpmf_pkg::SUM_W;

  // Add an offset of at most one full ring to a pointer and wrap once.
  function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(p) + (CW+1)'(k);
    if (s >= (CW+1)'(lpmf_pkg::STORE_DEPTH)) begin
      s = s - (CW+1)'(lpmf_pkg::STORE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  lpmf_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic          wip_r, wip_nxt;
  logic [7:0]    head_r, head_nxt;
  logic [RW-1:0] iss_cnt_r, iss_cnt_nxt;
  logic [RW-1:0] emit_cnt_r, emit_cnt_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic          rdpend_r, rdpend_nxt;
  logic          split_r, split_nxt;

  logic                       accept;
  lpmf_pkg::op_t              op;
  logic [lpmf_pkg::LIM_W-1:0] lim_sat;
  logic                       rd_ok;
  logic                       rd_full;
  logic                       stream_load;
  logic                       stream_issue;
  logic [SW-1:0]              need;
  logic [SW-1:0]              take;

  assign in_stall = !((state_r == lpmf_pkg::S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign op       = lpmf_pkg::op_t'(in_operation);

  always_comb begin
    lim_sat = in_read_limit;
    if (in_read_limit > lpmf_pkg::LIM_W'(lpmf_pkg::MAX_READ)) begin
      lim_sat = lpmf_pkg::LIM_W'(lpmf_pkg::MAX_READ);
    end
    rd_ok        = !wip_r && (in_read_limit != '0) && (occ_r != '0);
    rd_full      = head_r <= 8'(lim_sat);
    need         = SW'(occ_r) + SW'(in_msg_length) + SW'(1);
    take         = rd_full ? SW'(head_r) + SW'(1) : SW'(lim_sat);
    stream_load  = rdpend_r && out_free;
    stream_issue = (iss_cnt_r != '0) && (!rdpend_r || stream_load);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpmf_pkg::S_IDLE: begin
        if (accept && (op == lpmf_pkg::OP_READ) && rd_ok) begin
          state_nxt = rd_full ? lpmf_pkg::S_HEAD_CAP : lpmf_pkg::S_STREAM;
        end
      end
      lpmf_pkg::S_HEAD_CAP: begin
        state_nxt = (emit_cnt_r == '0) ? lpmf_pkg::S_ZERO_BEAT : lpmf_pkg::S_STREAM;
      end
      lpmf_pkg::S_STREAM: begin
        if (stream_load && (emit_cnt_r == RW'(1))) begin
          state_nxt = split_r ? lpmf_pkg::S_PATCH : lpmf_pkg::S_IDLE;
        end
      end
      lpmf_pkg::S_ZERO_BEAT: begin
        if (out_free) begin
          state_nxt = lpmf_pkg::S_IDLE;
        end
      end
      lpmf_pkg::S_PATCH: begin
        state_nxt = lpmf_pkg::S_IDLE;
      end
      default: begin
        state_nxt = lpmf_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath, memory requests and result beats
  always_comb begin
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    occ_nxt      = occ_r;
    pend_nxt     = pend_r;
    wip_nxt      = wip_r;
    head_nxt     = head_r;
    iss_cnt_nxt  = iss_cnt_r;
    emit_cnt_nxt = emit_cnt_r;
    rd_addr_nxt  = rd_addr_r;
    rdpend_nxt   = rdpend_r;
    split_nxt    = split_r;
    ram_req      = '0;
    beat         = '0;
    beat.status  = lpmf_pkg::STAT_OK;
    beat.last    = 1'b1;

    case (state_r)
      lpmf_pkg::S_IDLE: begin
        if (accept) begin
          beat.load = 1'b1;
          case (op)
            lpmf_pkg::OP_BEGIN: begin
              if (wip_r) begin
                beat.status = lpmf_pkg::STAT_SEQ;
              end else if (need > SW'(lpmf_pkg::STORE_DEPTH)) begin
                beat.status = lpmf_pkg::STAT_NOSPACE;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = wp_r;
                ram_req.wdata = in_msg_length;
                wp_nxt        = ptr_add(wp_r, CW'(1));
                occ_nxt       = need[CW-1:0];
                pend_nxt      = in_msg_length;
                wip_nxt       = in_msg_length != 8'd0;
                if (occ_r == '0) begin
                  head_nxt = in_msg_length;
                end
              end
            end
            lpmf_pkg::OP_WRITE: begin
              if (!wip_r) begin
                beat.status = lpmf_pkg::STAT_SEQ;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = wp_r;
                ram_req.wdata = in_payload;
                wp_nxt        = ptr_add(wp_r, CW'(1));
                pend_nxt      = pend_r - 8'd1;
                wip_nxt       = pend_r != 8'd1;
              end
            end
            lpmf_pkg::OP_READ: begin
              if (wip_r) begin
                beat.status = lpmf_pkg::STAT_SEQ;
              end else if (in_read_limit == '0) begin
                beat.status = lpmf_pkg::STAT_ZEROLIM;
              end else if (occ_r == '0) begin
                beat.status = lpmf_pkg::STAT_EMPTY;
              end else begin
                // The result beats come later from the stream states.
                beat.load   = 1'b0;
                rp_nxt      = ptr_add(rp_r, take[CW-1:0]);
                occ_nxt     = (SW'(occ_r) >= take) ? CW'(SW'(occ_r) - take) : '0;
                rd_addr_nxt = ptr_add(rp_r, CW'(1));
                rdpend_nxt  = 1'b0;
                split_nxt   = !rd_full;
                if (rd_full) begin
                  iss_cnt_nxt   = RW'(head_r);
                  emit_cnt_nxt  = RW'(head_r);
                  // Fetch the next head length ahead of the payload.
                  ram_req.re    = 1'b1;
                  ram_req.raddr = rp_nxt;
                end else begin
                  iss_cnt_nxt  = RW'(lim_sat);
                  emit_cnt_nxt = RW'(lim_sat);
                  head_nxt     = head_r - 8'(lim_sat);
                end
              end
            end
            lpmf_pkg::OP_CLEAR: begin
              wp_nxt   = '0;
              rp_nxt   = '0;
              occ_nxt  = '0;
              pend_nxt = 8'd0;
              wip_nxt  = 1'b0;
              head_nxt = 8'd0;
            end
            default: begin
              beat.load = 1'b0;
            end
          endcase
        end
      end
      lpmf_pkg::S_HEAD_CAP: begin
        head_nxt = ram_rdata;
      end
      lpmf_pkg::S_STREAM: begin
        if (stream_issue) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = rd_addr_r;
          rd_addr_nxt   = ptr_add(rd_addr_r, CW'(1));
          iss_cnt_nxt   = iss_cnt_r - RW'(1);
        end
        if (stream_load) begin
          beat.load       = 1'b1;
          beat.data       = ram_rdata;
          beat.byte_valid = 1'b1;
          beat.last       = emit_cnt_r == RW'(1);
          emit_cnt_nxt    = emit_cnt_r - RW'(1);
        end
        // Hold the fetched byte until the output stage takes it.
        rdpend_nxt = stream_issue || (rdpend_r && !stream_load);
      end
      lpmf_pkg::S_ZERO_BEAT: begin
        beat.load = out_free;
      end
      lpmf_pkg::S_PATCH: begin
        // Rewrite the slot of the last byte sent as the remainder's length.
        ram_req.we    = 1'b1;
        ram_req.waddr = rp_r;
        ram_req.wdata = head_r;
      end
      default: begin
        beat.load = 1'b0;
      end
    endcase

    beat.used = occ_nxt;
    beat.head = (occ_nxt != '0) ? head_nxt : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lpmf_pkg::S_IDLE;
      wp_r       <= '0;
      rp_r       <= '0;
      occ_r      <= '0;
      pend_r     <= 8'd0;
      wip_r      <= 1'b0;
      head_r     <= 8'd0;
      iss_cnt_r  <= '0;
      emit_cnt_r <= '0;
      rdpend_r   <= 1'b0;
      split_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wp_r       <= wp_nxt;
      rp_r       <= rp_nxt;
      occ_r      <= occ_nxt;
      pend_r     <= pend_nxt;
      wip_r      <= wip_nxt;
      head_r     <= head_nxt;
      iss_cnt_r  <= iss_cnt_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      rdpend_r   <= rdpend_nxt;
      split_r    <= split_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
  end

endmodule

FILE: rtl/length_prefixed_message_fifo_top.sv
// Top level of the length-prefixed message FIFO.
//
// A byte ring that holds messages, each a length byte and its payload.
// Input channel (in_*): one command per beat: begin write, write byte, read, clear.
// Result channel (out_*): status, optional payload byte with a last mark, the
// occupied byte count and the head message length after the command.
// Begin, write byte, clear and every error give one result, registered in the
// cycle after the command; with the result channel flowing, one such command
// is taken every cycle.
// A read of n bytes streams the payload from the ring memory at one byte per
// cycle while the result channel flows, through its registered read port,
// and takes no command until done: a whole message first captures the next
// length lookup, a split message then writes its remainder length back. A
// zero-length message gives a single result with no payload byte.
// Reset empties the ring at once; the memory contents need no clearing.
// A stall on the result channel holds the current result and pauses the
// read stream; no command is taken while a result cannot be stored.
module length_prefixed_message_fifo_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_operation,
  input  logic [7:0]                 in_msg_length,
  input  logic [7:0]                 in_payload,
  input  logic [lpmf_pkg::LIM_W-1:0] in_read_limit,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_status,
  output logic [7:0]                 out_out_byte,
  output logic                       out_byte_valid,
  output logic                       out_last,
  output logic [lpmf_pkg::CNT_W-1:0] out_used_bytes,
  output logic [7:0]                 out_head_length
);

  lpmf_pkg::ram_req_t ram_req;
  lpmf_pkg::beat_t    beat;
  logic [7:0]         ram_rdata;
  logic               out_free;

  lpmf_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_msg_length (in_msg_length),
    .in_payload    (in_payload),
    .in_read_limit (in_read_limit),
    .out_free      (out_free),
    .ram_req       (ram_req),
    .ram_rdata     (ram_rdata),
    .beat          (beat)
  );

  lpmf_ram #(
    .WIDTH (8),
    .DEPTH (lpmf_pkg::STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  lpmf_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .beat            (beat),
    .free            (out_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_out_byte    (out_out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_last        (out_last),
    .out_used_bytes  (out_used_bytes),
    .out_head_length (out_head_length)
  );

  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> out_status == lpmf_pkg::STAT_OK)
    else $error("payload beat with error status");

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_used_bytes <= lpmf_pkg::CNT_W'(lpmf_pkg::STORE_DEPTH))
    else $error("occupied count beyond ring size");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_used_bytes == '0) |-> out_head_length == 8'd0)
    else $error("head length reported on empty ring");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("command taken in the middle of a read stream");

endmodule
